@@ rtl/ghash_accumulator_defines.svh @@
// Assertion macros shared by the GHASH accumulator RTL
`ifndef GHASH_ACCUMULATOR_DEFINES_SVH
`define GHASH_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gha_pkg.sv @@
// Package for the GHASH accumulator: widths, digit size and control types
package gha_pkg;

  localparam int BLK_W      = 128;
  localparam int HALF_W     = 64;
  localparam int DIGIT_BITS = 8;
  // multiplier digits per block, last one may be partial
  localparam int STEPS      = (BLK_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int CNT_W      = (STEPS > 1) ? $clog2(STEPS) : 1;

  // reduction byte xored into the top of V on a carry out of x^127
  localparam logic [7:0] GH_REDUCE = 8'hE1;

  // configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture input beat, key and start value
    logic step;    // process one digit of the multiplier
    logic commit;  // write product to accumulator and output register
  } gha_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic last_step;  // current digit is the final one
  } gha_stat_t;

endpackage

@@ rtl/gha_ctrl.sv @@
// Controller FSM of the GHASH accumulator: sequencing and handshakes
module gha_ctrl
  import gha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  gha_stat_t stat,
  output gha_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       slot_free;

  assign slot_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (stat.last_step) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output beat valid: set on commit, cleared when taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.commit) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

@@ rtl/gha_dp.sv @@
// Datapath of the GHASH accumulator: key, accumulator and digit-serial multiplier
module gha_dp
  import gha_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [HALF_W-1:0]  cfg_wdata,
  input  logic [BLK_W-1:0]   in_data,
  input  logic               in_start,
  input  logic               in_final,
  input  gha_cmd_t           cmd,
  output gha_stat_t          stat,
  output logic [BLK_W-1:0]   out_data,
  output logic               out_final
);

  logic [HALF_W-1:0] key_hi_r, key_lo_r;
  logic [BLK_W-1:0]  acc_r;
  logic [BLK_W-1:0]  x_r, x_nxt;
  logic [BLK_W-1:0]  z_r, z_nxt;
  logic [BLK_W-1:0]  v_r, v_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              fin_r;
  logic [BLK_W-1:0]  out_data_r;
  logic              out_final_r;
  logic [BLK_W-1:0]  start_val;

  assign stat.last_step = (cnt_r == CNT_W'(STEPS - 1));
  assign out_data  = out_data_r;
  assign out_final = out_final_r;

  // block word: high half in the upper bits, bit 127 is x^0
  assign start_val = (in_start ? '0 : acc_r)
                   ^ {in_data[HALF_W-1:0], in_data[BLK_W-1:HALF_W]};

  // one digit: DIGIT_BITS shift-and-add steps, MSB of X first
  always_comb begin
    z_nxt = z_r;
    v_nxt = v_r;
    for (int k = 0; k < DIGIT_BITS; k++) begin
      if (x_r[BLK_W-1-k]) z_nxt = z_nxt ^ v_nxt;
      if (v_nxt[0]) v_nxt = {1'b0, v_nxt[BLK_W-1:1]} ^ {GH_REDUCE, {(BLK_W-8){1'b0}}};
      else          v_nxt = {1'b0, v_nxt[BLK_W-1:1]};
    end
    x_nxt = x_r << DIGIT_BITS;
  end

  // key registers, accumulator and digit counter (control-relevant state)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      acc_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_HIGH: key_hi_r <= cfg_wdata;
          CFG_KEY_LOW:  key_lo_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.commit) acc_r <= z_r;
      if (cmd.load) cnt_r <= '0;
      else if (cmd.step) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // multiplier working registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= start_val;
      z_r   <= '0;
      v_r   <= {key_hi_r, key_lo_r};
      fin_r <= in_final;
    end else if (cmd.step) begin
      x_r <= x_nxt;
      z_r <= z_nxt;
      v_r <= v_nxt;
    end
    if (cmd.commit) begin
      out_data_r  <= {z_r[HALF_W-1:0], z_r[BLK_W-1:HALF_W]};
      out_final_r <= fin_r;
    end
  end

endmodule

@@ rtl/ghash_accumulator.sv @@
// Top level of the GHASH accumulator: controller, datapath and checks
//
//  channel | dir | beat contents
//  in_     | in  | tdata: block_high[63:0], block_low[127:64]; tuser: start_new;
//          |     | tlast: final_block
//  out_    | out | tdata: digest_high[63:0], digest_low[127:64]; tlast: digest_valid
//  cfg_    | in  | cfg_index 0 key_high, 1 key_low; cfg_wdata 64 bits
//
// A block passes through a load, one step per multiplier digit, and a commit
// into the output register; the digit-serial multiplier and the accumulator
// feedback let a new block in only once the previous one has committed.
// A new block is taken while the previous digest still waits on out_tready;
// commit waits only if the output register is still full.
// rst_n is synchronous: key, accumulator and control state clear to zero.
`include "ghash_accumulator_defines.svh"

module ghash_accumulator
  import gha_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [BLK_W-1:0]   in_tdata,   // block_high, block_low
  input  logic               in_tuser,   // start_new
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [BLK_W-1:0]   out_tdata,  // digest_high, digest_low
  output logic               out_tlast,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [HALF_W-1:0]  cfg_wdata
);

  gha_cmd_t  cmd;
  gha_stat_t stat;

  gha_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  gha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .in_start  (in_tuser),
    .in_final  (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata),
    .out_final (out_tlast)
  );

  // checks
  `GHA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `GHA_ASSERT_NEXT(a_commit_shows_beat, cmd.commit, out_tvalid, "commit without output beat")
  `GHA_ASSERT_NOW(a_cmd_exclusive, 1'b1, $onehot0({cmd.load, cmd.step, cmd.commit}), "overlapping commands")
  `GHA_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_tvalid || out_tready, "output beat overwritten")

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the GHASH accumulator: GF(2^128) predictor, stimulus and checks
`timescale 1ns / 100ps

module testbench;
  import gha_pkg::*;

  localparam int          WATCHDOG_CYCLES = 5000;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          TAIL_CYCLES     = 40;
  localparam int          MAX_REPORTS     = 10;
  localparam int          BLOCKS_PER_KEY  = 100;
  localparam logic [127:0] REDUCE_POLY    = {8'hE1, 120'h0};
  localparam logic [63:0]  ONE_HIGH       = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
    logic        last;
  } digest_t;

  // Running GHASH state and the queue of digests still owed by the block
  class ghash_digest_board;
    logic [127:0] hash_key     = '0;
    logic [127:0] running_hash = '0;
    digest_t      pending_digests[$];
    int           mismatches   = 0;
    int           digests_seen = 0;
    int           finals_seen  = 0;
    int           blocks_taken = 0;

    // multiply in the reflected GCM field, x^0 in bit 127
    function logic [127:0] gf128_mult(logic [127:0] x, logic [127:0] h);
      logic [127:0] z;
      logic [127:0] v;
      z = '0;
      v = h;
      for (int i = 0; i < 128; i++) begin
        if (x[127-i]) z ^= v;
        v = v[0] ? ((v >> 1) ^ REDUCE_POLY) : (v >> 1);
      end
      return z;
    endfunction

    function void absorb_block(logic [63:0] blk_high, logic [63:0] blk_low,
                               logic start_new, logic final_block);
      logic [127:0] sum;
      digest_t      d;
      sum = (start_new ? 128'h0 : running_hash) ^ {blk_high, blk_low};
      running_hash = gf128_mult(sum, hash_key);
      d.high = running_hash[127:64];
      d.low  = running_hash[63:0];
      d.last = final_block;
      pending_digests.push_back(d);
      blocks_taken++;
    endfunction

    function void check_digest(logic [63:0] got_high, logic [63:0] got_low, logic got_last);
      digest_t d;
      digests_seen++;
      if (got_last) finals_seen++;
      if (pending_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: digest beat with nothing outstanding: high %h low %h last %b",
                   $realtime, got_high, got_low, got_last);
        return;
      end
      d = pending_digests.pop_front();
      if (got_high !== d.high || got_low !== d.low || got_last !== d.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: digest mismatch", $realtime);
          $display("  expected high %h low %h last %b", d.high, d.low, d.last);
          $display("  actual   high %h low %h last %b", got_high, got_low, got_last);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [BLK_W-1:0]   in_tdata;   // block_high [63:0], block_low [127:64]
  logic               in_tuser;   // start_new
  logic               in_tlast;   // final_block
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [BLK_W-1:0]   out_tdata;  // digest_high [63:0], digest_low [127:64]
  logic               out_tlast;  // digest_valid
  logic               cfg_we;
  logic               cfg_index;
  logic [HALF_W-1:0]  cfg_wdata;

  ghash_digest_board board;
  int   tx_idle_pct   = 0;
  int   rx_stall_pct  = 0;
  int   blocks_sent   = 0;
  int   keys_loaded   = 0;
  int   quiet_cycles  = 0;
  logic hold_request  = 1'b0;
  logic rx_hold       = 1'b0;

  ghash_accumulator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // record every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.absorb_block(in_tdata[63:0], in_tdata[127:64], in_tuser, in_tlast);
  end

  // result side: check accepted beats, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_digest(out_tdata[63:0], out_tdata[127:64], out_tlast);
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off, counted here once requested
  initial begin : rx_hold_ctl
    wait (hold_request);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no beat for %0d cycles, %0d digests outstanding",
                 quiet_cycles, board.pending_digests.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [63:0] random_half();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // both key halves, high then low; the block must be idle
  task automatic load_key(input logic [63:0] key_hi, input logic [63:0] key_lo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_HIGH;
    cfg_wdata <= key_hi;
    @(posedge clk);
    cfg_index <= CFG_KEY_LOW;
    cfg_wdata <= key_lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.hash_key = {key_hi, key_lo};
    keys_loaded++;
  endtask

  // one beat on in_, with random idle cycles ahead of it; tvalid stays high on return
  task automatic send_block(input logic [63:0] blk_hi, input logic [63:0] blk_lo,
                            input logic start_new, input logic final_block);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {blk_lo, blk_hi};
    in_tuser  <= start_new;
    in_tlast  <= final_block;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    blocks_sent++;
  endtask

  // stop sending and let every owed digest come back
  task automatic wait_all_digests();
    in_tvalid <= 1'b0;
    while (board.pending_digests.size() != 0) @(posedge clk);
  endtask

  // well-formed message, or with noise the flags are random per beat
  task automatic send_message(input int len, input bit noisy);
    for (int n = 0; n < len; n++) begin
      if (noisy) begin
        send_block(random_half(), random_half(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      end else begin
        send_block(random_half(), random_half(), n == 0, n == len - 1);
      end
    end
  endtask

  task automatic send_random_blocks(input int count);
    int target;
    target = blocks_sent + count;
    while (blocks_sent < target)
      send_message($urandom_range(1, 8), $urandom_range(99) < 15);
  endtask

  // stimulus
  initial begin
    logic [63:0] ext_hi[4];
    logic [63:0] ext_lo[4];
    int          fails;
    board = new;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    in_tlast  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_KEY_HIGH;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key still zero after reset: every digest is zero
    send_block('1, '1, 1'b1, 1'b0);
    send_block(64'h0123_4567_89ab_cdef, '1, 1'b0, 1'b1);
    wait_all_digests();

    // unit key: digest equals the running xor of the blocks
    load_key(ONE_HIGH, '0);
    send_block('1, '1, 1'b1, 1'b0);
    send_block('0, '0, 1'b0, 1'b1);
    send_block(64'h1, ONE_HIGH, 1'b0, 1'b0);   // no start after a final block
    send_block(ONE_HIGH, 64'h1, 1'b1, 1'b1);   // single-block message
    wait_all_digests();

    // all-ones key against extreme blocks
    load_key('1, '1);
    send_block('0, '0, 1'b1, 1'b0);
    send_block('1, '1, 1'b0, 1'b0);
    send_block(ONE_HIGH, '0, 1'b0, 1'b0);
    send_block('0, 64'h1, 1'b0, 1'b1);
    send_block('1, '0, 1'b1, 1'b1);
    wait_all_digests();

    // key x^127, then a key change in the middle of a message
    load_key('0, 64'h1);
    send_block(ONE_HIGH, '0, 1'b1, 1'b0);
    send_block('0, 64'h1, 1'b0, 1'b0);
    wait_all_digests();
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0);
    send_block(random_half(), random_half(), 1'b0, 1'b1);
    wait_all_digests();

    // random traffic under four idling regimes, three keys each
    ext_hi = '{'1, ONE_HIGH, 64'h0, 64'h0};
    ext_lo = '{'1, 64'h0, 64'h1, 64'h0};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      for (int k = 0; k < 3; k++) begin
        if (k == 0) begin
          load_key(ext_hi[ph], ext_lo[ph]);
        end else begin
          load_key({$urandom, $urandom}, {$urandom, $urandom});
        end
        send_random_blocks(BLOCKS_PER_KEY / 2);
        // sender pauses until the block has handed back everything
        wait_all_digests();
        if (ph == 0 && k == 1) begin
          // receiver holds off while beats keep coming, so in_tready must drop
          hold_request <= 1'b1;
          send_random_blocks(48);
        end
        send_random_blocks(BLOCKS_PER_KEY / 2);
        wait_all_digests();
      end
    end

    // drain and settle
    wait_all_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    fails = board.mismatches + board.pending_digests.size();
    if (board.pending_digests.size() != 0)
      $display("%0d digests never arrived", board.pending_digests.size());
    $display("ran %0d blocks under %0d keys, %0d digests checked, %0d of them final",
             board.blocks_taken, keys_loaded, board.digests_seen, board.finals_seen);
    $display("idling regimes: none, sender, receiver, both; one long receiver hold-off");
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fails);
      $display("status: fail");
    end
    $finish;
  end

endmodule
